>>> design/gtre_pkg.sv
package gtre_pkg;

  localparam int COEF_BITS      = 16;
  localparam int WARMUP_BITS    = 15;
  localparam int INTERVAL_BITS  = 16;
  localparam int LOG_BITS       = 32;
  localparam int CFG_INDEX_BITS = 3;

  // Register reset values.
  localparam int LOW_LIMIT_RESET      = 16812;
  localparam int HIGH_LIMIT_RESET     = 8406424;
  localparam int FAST_COEF_RESET      = 6554;
  localparam int SLOW_COEF_RESET      = 66;
  localparam int WARMUP_SAMPLES_RESET = 500;
  localparam int LOG_INTERVAL_RESET   = 1000;

  // State reset levels in whole LSB: 2.048645 V, 3.0 V and 1.0 V.
  localparam longint FILTER_RESET_LSB  = 3444357;
  localparam longint LOWEST_RESET_LSB  = 5043856;
  localparam longint HIGHEST_RESET_LSB = 1681285;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOW_LIMIT      = 3'd0,
    CFG_HIGH_LIMIT     = 3'd1,
    CFG_FAST_COEF      = 3'd2,
    CFG_SLOW_COEF      = 3'd3,
    CFG_WARMUP_SAMPLES = 3'd4,
    CFG_LOG_INTERVAL   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_BITS-1:0]     fast_coef;
    logic [COEF_BITS-1:0]     slow_coef;
    logic [WARMUP_BITS-1:0]   warmup_samples;
    logic [INTERVAL_BITS-1:0] log_interval;
  } gtre_cfg_t;

  typedef struct packed {
    logic accepted;
    logic warming_up;
    logic log_strobe;
  } gtre_flags_t;

endpackage

>>> design/gtre_filter.sv
module gtre_filter
  import gtre_pkg::*;
#(
  parameter int LEVEL_W = 41
) (
  input  logic [LEVEL_W-1:0]   value,
  input  logic [LEVEL_W-1:0]   target,
  input  logic [COEF_BITS-1:0] coef,
  output logic [LEVEL_W-1:0]   updated
);

  localparam int PROD_W = LEVEL_W + COEF_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (COEF_BITS - 1);

  logic               up;
  logic [LEVEL_W-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  rounded;
  logic [LEVEL_W-1:0] step_raw;
  logic [LEVEL_W-1:0] step;

  always_comb begin
    up       = (target >= value);
    mag      = up ? (target - value) : (value - target);
    prod     = {{LEVEL_W{1'b0}}, coef} * {{COEF_BITS{1'b0}}, mag};
    // Round half away from zero on the magnitude.
    rounded  = prod + HALF;
    step_raw = rounded[PROD_W-1:COEF_BITS];
    step     = (step_raw > mag) ? mag : step_raw;
    updated  = up ? (value + step) : (value - step);
  end

endmodule

>>> design/gtre_state.sv
module gtre_state
  import gtre_pkg::*;
#(
  parameter int CODE_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [CODE_BITS-1:0]                raw_code,
  input  logic [CODE_BITS:0]                  low_limit,
  input  logic [CODE_BITS:0]                  high_limit,
  input  gtre_cfg_t                           cfg,
  output gtre_flags_t                         flags,
  output logic [CODE_BITS+FRAC_BITS:0]        filtered_level,
  output logic [CODE_BITS+FRAC_BITS:0]        min_level,
  output logic [CODE_BITS+FRAC_BITS:0]        max_level,
  output logic signed [CODE_BITS+FRAC_BITS+1:0] peak_to_peak,
  output logic [LOG_BITS-1:0]                 log_count
);

  localparam int LIMIT_W = CODE_BITS + 1;
  localparam int LEVEL_W = CODE_BITS + 1 + FRAC_BITS;
  localparam int SPAN_W  = LEVEL_W + 1;

  localparam logic [LEVEL_W-1:0] FILTER_RESET  = LEVEL_W'(FILTER_RESET_LSB) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LOWEST_RESET  = LEVEL_W'(LOWEST_RESET_LSB) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] HIGHEST_RESET = LEVEL_W'(HIGHEST_RESET_LSB) << FRAC_BITS;

  logic [LEVEL_W-1:0]       filter_value, filter_value_next;
  logic [LEVEL_W-1:0]       lowest_seen, lowest_seen_next;
  logic [LEVEL_W-1:0]       highest_seen, highest_seen_next;
  logic signed [SPAN_W-1:0] span_value, span_value_next;
  logic [WARMUP_BITS-1:0]   warmup_count, warmup_count_next;
  logic [INTERVAL_BITS-1:0] skip_count, skip_count_next;
  logic [LOG_BITS-1:0]      log_counter, log_counter_next;

  logic [LIMIT_W-1:0]   level;
  logic [LEVEL_W-1:0]   target;
  logic [COEF_BITS-1:0] coef;
  logic [LEVEL_W-1:0]   filter_upd;
  logic                 acc;
  logic                 warm_phase;
  logic                 steady;
  logic                 new_high;
  logic                 new_low;
  logic                 log_hit;

  gtre_filter #(
    .LEVEL_W (LEVEL_W)
  ) u_filter (
    .value   (filter_value),
    .target  (target),
    .coef    (coef),
    .updated (filter_upd)
  );

  always_comb begin
    level      = {1'b1, {CODE_BITS{1'b0}}} - {1'b0, raw_code};
    acc        = (level > low_limit) && (level < high_limit);
    warm_phase = (warmup_count < cfg.warmup_samples);
    target     = {level, {FRAC_BITS{1'b0}}};
    coef       = warm_phase ? cfg.fast_coef : cfg.slow_coef;
    steady     = acc && !warm_phase;

    filter_value_next = acc ? filter_upd : filter_value;
    new_high          = steady && (filter_upd > highest_seen);
    new_low           = steady && (filter_upd < lowest_seen);
    highest_seen_next = new_high ? filter_upd : highest_seen;
    lowest_seen_next  = new_low ? filter_upd : lowest_seen;
    // The span is refreshed only when an extreme moves.
    span_value_next   = (new_high || new_low)
                        ? ($signed({1'b0, highest_seen_next}) - $signed({1'b0, lowest_seen_next}))
                        : span_value;

    warmup_count_next = (acc && warm_phase) ? (warmup_count + 1'b1) : warmup_count;

    log_hit          = (skip_count >= cfg.log_interval);
    skip_count_next  = steady ? (log_hit ? '0 : (skip_count + 1'b1)) : skip_count;
    log_counter_next = (steady && log_hit) ? (log_counter + 1'b1) : log_counter;

    flags.accepted   = acc;
    flags.warming_up = acc && warm_phase;
    flags.log_strobe = steady && log_hit;
  end

  assign filtered_level = filter_value_next;
  assign min_level      = lowest_seen_next;
  assign max_level      = highest_seen_next;
  assign peak_to_peak   = span_value_next;
  assign log_count      = log_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_value <= FILTER_RESET;
      lowest_seen  <= LOWEST_RESET;
      highest_seen <= HIGHEST_RESET;
      span_value   <= '0;
      warmup_count <= '0;
      skip_count   <= '0;
      log_counter  <= '0;
    end else if (step) begin
      filter_value <= filter_value_next;
      lowest_seen  <= lowest_seen_next;
      highest_seen <= highest_seen_next;
      span_value   <= span_value_next;
      warmup_count <= warmup_count_next;
      skip_count   <= skip_count_next;
      log_counter  <= log_counter_next;
    end
  end

endmodule

>>> design/gated_two_rate_ema_with_min_max.sv
// Range-gated two-rate exponential filter with min/max tracking. Each raw code is inverted
// to 2^CODE_BITS - code and filtered only when it lies strictly between low_limit and
// high_limit. The first warmup_samples accepted samples use fast_coef, later ones use
// slow_coef and update the extremes, peak-to-peak and the decimated log strobe. Every
// input transfer yields exactly one result transfer. The block takes one item per clock
// while the output is not stalled: the input register feeds a combinational update (one
// 16 x 41 bit multiply and the extreme compares) whose result lands in the output
// register, so the filter state feedback loop sets the clock limit. Configuration writes
// take effect at the next edge and should be made while idle.
module gated_two_rate_ema_with_min_max
  import gtre_pkg::*;
#(
  parameter int CODE_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [CODE_BITS-1:0]                  raw_code,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  accepted,
  output logic                                  warming_up,
  output logic [CODE_BITS+FRAC_BITS:0]          filtered_level,
  output logic [CODE_BITS+FRAC_BITS:0]          min_level,
  output logic [CODE_BITS+FRAC_BITS:0]          max_level,
  output logic signed [CODE_BITS+FRAC_BITS+1:0] peak_to_peak,
  output logic                                  log_strobe,
  output logic [LOG_BITS-1:0]                   log_count,
  input  logic                                  cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
  input  logic [CODE_BITS:0]                    cfg_data
);

  localparam int LIMIT_W = CODE_BITS + 1;
  localparam int LEVEL_W = CODE_BITS + 1 + FRAC_BITS;
  localparam int SPAN_W  = LEVEL_W + 1;

  logic [LIMIT_W-1:0] low_limit;
  logic [LIMIT_W-1:0] high_limit;
  gtre_cfg_t          cfg;

  logic                 hold_valid;
  logic [CODE_BITS-1:0] hold_code;
  logic                 advance;
  logic                 step;

  gtre_flags_t              flags;
  logic [LEVEL_W-1:0]       level_next;
  logic [LEVEL_W-1:0]       min_next;
  logic [LEVEL_W-1:0]       max_next;
  logic signed [SPAN_W-1:0] span_next;
  logic [LOG_BITS-1:0]      count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit          <= LIMIT_W'(LOW_LIMIT_RESET);
      high_limit         <= LIMIT_W'(HIGH_LIMIT_RESET);
      cfg.fast_coef      <= COEF_BITS'(FAST_COEF_RESET);
      cfg.slow_coef      <= COEF_BITS'(SLOW_COEF_RESET);
      cfg.warmup_samples <= WARMUP_BITS'(WARMUP_SAMPLES_RESET);
      cfg.log_interval   <= INTERVAL_BITS'(LOG_INTERVAL_RESET);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LOW_LIMIT:      low_limit          <= cfg_data;
        CFG_HIGH_LIMIT:     high_limit         <= cfg_data;
        CFG_FAST_COEF:      cfg.fast_coef      <= cfg_data[COEF_BITS-1:0];
        CFG_SLOW_COEF:      cfg.slow_coef      <= cfg_data[COEF_BITS-1:0];
        CFG_WARMUP_SAMPLES: cfg.warmup_samples <= cfg_data[WARMUP_BITS-1:0];
        CFG_LOG_INTERVAL:   cfg.log_interval   <= cfg_data[INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The output register can take a new result when it is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_code <= raw_code;
    end
  end

  gtre_state #(
    .CODE_BITS (CODE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_state (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .raw_code       (hold_code),
    .low_limit      (low_limit),
    .high_limit     (high_limit),
    .cfg            (cfg),
    .flags          (flags),
    .filtered_level (level_next),
    .min_level      (min_next),
    .max_level      (max_next),
    .peak_to_peak   (span_next),
    .log_count      (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      accepted       <= flags.accepted;
      warming_up     <= flags.warming_up;
      log_strobe     <= flags.log_strobe;
      filtered_level <= level_next;
      min_level      <= min_next;
      max_level      <= max_next;
      peak_to_peak   <= span_next;
      log_count      <= count_next;
    end
  end

endmodule

>>> design/gtre_checker.sv
module gtre_checker
  import gtre_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                accepted,
  input logic                warming_up,
  input logic                log_strobe,
  input logic [LOG_BITS-1:0] log_count
);

  // Both sides come out of reset empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  // A waiting result keeps its log index.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(log_count)))
    else $error("stalled result changed");

  // A rejected sample neither filters fast nor logs.
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (!warming_up && !log_strobe))
    else $error("rejected sample raised a flag");

  // Log points come only from accepted steady samples.
  a_strobe_steady: assert property (@(posedge clk) disable iff (rst)
    (out_valid && log_strobe) |-> (accepted && !warming_up))
    else $error("log strobe outside steady operation");

endmodule

bind gated_two_rate_ema_with_min_max gtre_checker u_checker (.*);

>>> sim/gated_two_rate_ema_with_min_max_tb.sv
module gated_two_rate_ema_with_min_max_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gtre_pkg::*;

  localparam int CODE_BITS       = 24;
  localparam int FRAC_BITS       = 16;
  localparam int LEVEL_W         = CODE_BITS + FRAC_BITS + 1;
  localparam int SPAN_W          = LEVEL_W + 1;
  localparam int LIMIT_W         = CODE_BITS + 1;
  localparam int FULL_SCALE      = 1 << CODE_BITS;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int MAX_REPORTS     = 10;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_7 = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

  typedef struct {
    gtre_flags_t              flags;
    logic [LEVEL_W-1:0]       filtered_level;
    logic [LEVEL_W-1:0]       min_level;
    logic [LEVEL_W-1:0]       max_level;
    logic signed [SPAN_W-1:0] peak_to_peak;
    logic [LOG_BITS-1:0]      log_count;
  } ema_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CODE_BITS-1:0]      raw_code = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      accepted;
  logic                      warming_up;
  logic [LEVEL_W-1:0]        filtered_level;
  logic [LEVEL_W-1:0]        min_level;
  logic [LEVEL_W-1:0]        max_level;
  logic signed [SPAN_W-1:0]  peak_to_peak;
  logic                      log_strobe;
  logic [LOG_BITS-1:0]       log_count;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]        cfg_data = '0;

  // Predictor copy of the configuration and of the filter state.
  logic [LIMIT_W-1:0]       lo_limit = LIMIT_W'(LOW_LIMIT_RESET);
  logic [LIMIT_W-1:0]       hi_limit = LIMIT_W'(HIGH_LIMIT_RESET);
  gtre_cfg_t                ema_cfg = '{COEF_BITS'(FAST_COEF_RESET), COEF_BITS'(SLOW_COEF_RESET),
                                        WARMUP_BITS'(WARMUP_SAMPLES_RESET),
                                        INTERVAL_BITS'(LOG_INTERVAL_RESET)};
  logic [LEVEL_W-1:0]       ema_level = LEVEL_W'(FILTER_RESET_LSB << FRAC_BITS);
  logic [LEVEL_W-1:0]       lowest_level = LEVEL_W'(LOWEST_RESET_LSB << FRAC_BITS);
  logic [LEVEL_W-1:0]       highest_level = LEVEL_W'(HIGHEST_RESET_LSB << FRAC_BITS);
  logic signed [SPAN_W-1:0] level_span = '0;
  logic [WARMUP_BITS-1:0]   warm_count = '0;
  logic [INTERVAL_BITS-1:0] skip_count = '0;
  logic [LOG_BITS-1:0]      log_total = '0;

  ema_result_t    ema_results_due[$];
  int             mismatch_count = 0;
  int             burst_left = 0;
  int unsigned    stall_tick = 0;
  stall_pattern_t stall_mode = STALL_NONE;

  gated_two_rate_ema_with_min_max u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .raw_code       (raw_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .warming_up     (warming_up),
    .filtered_level (filtered_level),
    .min_level      (min_level),
    .max_level      (max_level),
    .peak_to_peak   (peak_to_peak),
    .log_strobe     (log_strobe),
    .log_count      (log_count),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // One exponential step toward the target, rounded half away from zero.
  // The step is clipped to the distance so the level never overshoots.
  function automatic logic [LEVEL_W-1:0] ema_step(input logic [LEVEL_W-1:0] cur,
                                                  input logic [LEVEL_W-1:0] target,
                                                  input logic [COEF_BITS-1:0] coef);
    logic        up;
    logic [63:0] mag;
    logic [63:0] step;
    up = target >= cur;
    mag = up ? 64'(target - cur) : 64'(cur - target);
    step = 64'(coef) * (mag >> COEF_BITS)
         + ((64'(coef) * mag[COEF_BITS-1:0] + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS);
    if (step > mag) step = mag;
    return up ? cur + step[LEVEL_W-1:0] : cur - step[LEVEL_W-1:0];
  endfunction

  function automatic ema_result_t advance_ema(input logic [CODE_BITS-1:0] code);
    ema_result_t        res;
    logic [LIMIT_W-1:0] level;
    logic [LEVEL_W-1:0] target;
    level = LIMIT_W'(FULL_SCALE - int'(code));
    res.flags = '0;
    if (level > lo_limit && level < hi_limit) begin
      res.flags.accepted = 1'b1;
      target = LEVEL_W'(level) << FRAC_BITS;
      if (warm_count < ema_cfg.warmup_samples) begin
        res.flags.warming_up = 1'b1;
        warm_count++;
        ema_level = ema_step(ema_level, target, ema_cfg.fast_coef);
      end else begin
        ema_level = ema_step(ema_level, target, ema_cfg.slow_coef);
        // Both extremes can move on one sample while max is still below min;
        // the span only depends on where they end up.
        if (ema_level > highest_level || ema_level < lowest_level) begin
          if (ema_level > highest_level) highest_level = ema_level;
          if (ema_level < lowest_level) lowest_level = ema_level;
          level_span = $signed({1'b0, highest_level}) - $signed({1'b0, lowest_level});
        end
        if (skip_count >= ema_cfg.log_interval) begin
          skip_count = '0;
          log_total++;
          res.flags.log_strobe = 1'b1;
        end else begin
          skip_count++;
        end
      end
    end
    res.filtered_level = ema_level;
    res.min_level = lowest_level;
    res.max_level = highest_level;
    res.peak_to_peak = level_span;
    res.log_count = log_total;
    return res;
  endfunction

  function automatic logic [CODE_BITS-1:0] code_for(input int level);
    return CODE_BITS'(FULL_SCALE - level);
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_coef();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [CODE_BITS-1:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    raw_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ema_results_due.push_back(advance_ema(code));
    burst_left--;
  endtask

  // Every sample yields a result, so an empty queue means the block has gone
  // quiet; the extra cycles cover its pipeline latency.
  task automatic drain_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (ema_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [LIMIT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LOW_LIMIT:      lo_limit = data;
      CFG_HIGH_LIMIT:     hi_limit = data;
      CFG_FAST_COEF:      ema_cfg.fast_coef = data[COEF_BITS-1:0];
      CFG_SLOW_COEF:      ema_cfg.slow_coef = data[COEF_BITS-1:0];
      CFG_WARMUP_SAMPLES: ema_cfg.warmup_samples = data[WARMUP_BITS-1:0];
      CFG_LOG_INTERVAL:   ema_cfg.log_interval = data[INTERVAL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] got);
    if (got !== exp) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
    end
  endtask

  task automatic test_reset_defaults();
    // Code zero inverts to full scale, above the default upper limit.
    send_sample('0);
    send_sample('1);
    send_sample(code_for(LOW_LIMIT_RESET));
    send_sample(code_for(LOW_LIMIT_RESET + 1));
    send_sample(code_for(HIGH_LIMIT_RESET - 1));
    send_sample(code_for(HIGH_LIMIT_RESET));
  endtask

  task automatic test_range_gate();
    drain_block();
    write_reg(CFG_LOW_LIMIT, '0);
    write_reg(CFG_HIGH_LIMIT, LIMIT_W'(FULL_SCALE + 1));
    write_reg(CFG_SPARE_6, '1);
    write_reg(CFG_SPARE_7, LIMIT_W'($urandom));
    send_sample('0);
    send_sample('1);
    // A window one LSB wide holds no level at all.
    drain_block();
    write_reg(CFG_LOW_LIMIT, LIMIT_W'(99));
    write_reg(CFG_HIGH_LIMIT, LIMIT_W'(100));
    send_sample(code_for(99));
    send_sample(code_for(100));
    drain_block();
    write_reg(CFG_LOW_LIMIT, '1);
    write_reg(CFG_HIGH_LIMIT, '0);
    send_sample(24'h800000);
    send_sample(code_for(1));
  endtask

  task automatic test_filter_coefficients();
    drain_block();
    write_reg(CFG_LOW_LIMIT, '0);
    write_reg(CFG_HIGH_LIMIT, '1);
    write_reg(CFG_FAST_COEF, '1);
    write_reg(CFG_SLOW_COEF, '0);
    write_reg(CFG_WARMUP_SAMPLES, LIMIT_W'(6));
    write_reg(CFG_LOG_INTERVAL, '0);
    send_sample(code_for(1000));
    send_sample(code_for(FULL_SCALE));
    send_sample(code_for(1));
    send_sample(code_for(5000000));
    drain_block();
    write_reg(CFG_SLOW_COEF, {{(LIMIT_W - COEF_BITS){1'b0}}, {COEF_BITS{1'b1}}});
    send_sample('0);
    send_sample('1);
  endtask

  task automatic test_lowered_counts();
    drain_block();
    write_reg(CFG_FAST_COEF, '0);
    write_reg(CFG_WARMUP_SAMPLES, LIMIT_W'(32767));
    send_sample(code_for(3000000));
    send_sample(code_for(9000000));
    // Warm-up limit now below the count: steady from here on.
    drain_block();
    write_reg(CFG_WARMUP_SAMPLES, LIMIT_W'(3));
    write_reg(CFG_LOG_INTERVAL, LIMIT_W'(65535));
    send_sample(code_for(12000000));
    send_sample(code_for(200));
    send_sample(code_for(7000000));
    // Interval now below the skip count: the next steady sample strobes.
    drain_block();
    write_reg(CFG_LOG_INTERVAL, LIMIT_W'(1));
    send_sample(code_for(8000000));
    send_sample(code_for(8000001));
  endtask

  task automatic test_random_phases();
    int                 low;
    int                 high;
    int                 win_lo;
    int                 win_hi;
    int                 center;
    int                 spread;
    int                 level;
    int                 pick;
    logic [LIMIT_W-1:0] junk;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: begin
          low = 0;
          high = FULL_SCALE + 1;
        end
        1: begin
          low = $urandom_range(0, FULL_SCALE - 2);
          high = low + $urandom_range(2, 100000);
        end
        2: begin
          low = $urandom_range(0, FULL_SCALE / 2);
          high = $urandom_range(FULL_SCALE / 2 + 2, (1 << LIMIT_W) - 1);
        end
        default: begin
          low = LOW_LIMIT_RESET;
          high = HIGH_LIMIT_RESET;
        end
      endcase
      drain_block();
      write_reg(CFG_LOW_LIMIT, LIMIT_W'(low));
      write_reg(CFG_HIGH_LIMIT, LIMIT_W'(high));
      // Upper data bits beyond a register's width must be dropped.
      junk = LIMIT_W'($urandom);
      junk[COEF_BITS-1:0] = pick_coef();
      write_reg(CFG_FAST_COEF, junk);
      junk = LIMIT_W'($urandom);
      junk[COEF_BITS-1:0] = pick_coef();
      write_reg(CFG_SLOW_COEF, junk);
      junk = LIMIT_W'($urandom);
      junk[WARMUP_BITS-1:0] = ($urandom_range(0, 7) == 0) ? '0 : WARMUP_BITS'($urandom_range(1, 40));
      write_reg(CFG_WARMUP_SAMPLES, junk);
      junk = LIMIT_W'($urandom);
      junk[INTERVAL_BITS-1:0] = ($urandom_range(0, 7) == 0) ? '1 : INTERVAL_BITS'($urandom_range(0, 12));
      write_reg(CFG_LOG_INTERVAL, junk);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, LIMIT_W'($urandom));

      win_lo = low + 1;
      win_hi = (high - 1 > FULL_SCALE) ? FULL_SCALE : high - 1;
      spread = (win_hi - win_lo) / 8 + 1;
      center = win_lo;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 20 == 0) center = $urandom_range(win_lo, win_hi);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_sample(CODE_BITS'($urandom));
        end else begin
          if (pick < 60) level = center + int'($urandom_range(0, 2 * spread)) - spread;
          else level = $urandom_range(win_lo, win_hi);
          if (level < win_lo) level = win_lo;
          if (level > win_hi) level = win_hi;
          send_sample(code_for(level));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_pattern_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick[1:0] == 2'b01);
    endcase
  end

  always @(posedge clk) begin
    ema_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (ema_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transfer with no sample outstanding", $time);
      end else begin
        due = ema_results_due.pop_front();
        check_field("accepted", due.flags.accepted, accepted);
        check_field("warming_up", due.flags.warming_up, warming_up);
        check_field("filtered_level", due.filtered_level, filtered_level);
        check_field("min_level", due.min_level, min_level);
        check_field("max_level", due.max_level, max_level);
        check_field("peak_to_peak", due.peak_to_peak, peak_to_peak);
        check_field("log_strobe", due.flags.log_strobe, log_strobe);
        check_field("log_count", due.log_count, log_count);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) quiet = 0;
      else quiet++;
    end
    $display("gated_two_rate_ema_with_min_max test failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_range_gate();
    test_filter_coefficients();
    test_lowered_counts();
    test_random_phases();
    drain_block();
    if (mismatch_count == 0 && ema_results_due.size() == 0) begin
      $display("gated_two_rate_ema_with_min_max test passed");
    end else begin
      $display("gated_two_rate_ema_with_min_max test failed");
    end
    $finish;
  end

endmodule
